[src/ismt_pkg.sv]
`default_nettype none

package ismt_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int ELEM_W       = 32;
    localparam int COUNT_W      = 5;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_PRESENT = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // per-cycle commands broadcast along the row of cells
    typedef struct packed {
        logic cmp;
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

`default_nettype wire

[src/ismt_cell.sv]
`default_nettype none

module ismt_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  wire                        i_clk,
    input  ismt_pkg::t_cell_ctl        i_ctl,
    input  wire [ismt_pkg::ELEM_W-1:0] i_key,
    input  wire [CNT_W-1:0]            i_held,
    input  wire [IDX_W-1:0]            i_pos,
    input  wire [ismt_pkg::ELEM_W-1:0] i_next_data,
    output wire [ismt_pkg::ELEM_W-1:0] o_data,
    output wire                        o_hit
);

    logic [ismt_pkg::ELEM_W-1:0] r_data;
    logic                        r_hit;
    logic                        w_live;
    logic                        w_shift;
    logic                        w_append;

    assign w_live   = CNT_W'(INDEX) < i_held;
    // cells from the removed slot up to the one before the last valid one pull from the right
    assign w_shift  = i_ctl.rem && (IDX_W'(INDEX) >= i_pos) && (CNT_W'(INDEX + 1) < i_held);
    assign w_append = i_ctl.ins && (CNT_W'(INDEX) == i_held);

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_hit <= w_live && (r_data == i_key);
        end
        if (w_append) begin
            r_data <= i_key;
        end else if (w_shift) begin
            r_data <= i_next_data;
        end
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;

endmodule

`default_nettype wire

[src/integer_set_membership_table_top.sv]
`default_nettype none

// Set of distinct signed 32-bit values kept in insertion order in a row of
// CAPACITY cells. A request on the s_axis side carries the action in tuser
// (insert, remove, query, clear) and the value in tdata; each request yields
// one result on the m_axis side with the status in tuser and the count in
// tdata. A request passes a compare state, in which every cell compares
// its word against the value, and then an update state, in which the table
// is updated and the result is registered (an append into the next free
// cell, or a one-step shift of the cells behind a removed entry); the update
// waits while an earlier result is still held. A new request is taken in the
// update cycle of the previous one. Stored words are not cleared at reset;
// only the count is.

module integer_set_membership_table_top #(
    parameter int CAPACITY = ismt_pkg::CAPACITY_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output wire         s_axis_tready,
    input  wire [31:0]  s_axis_tdata,   // [31:0] element
    input  wire [1:0]   s_axis_tuser,   // [1:0] action
    output wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    output wire [7:0]   m_axis_tdata,   // [4:0] count, [7:5] zero
    output wire [1:0]   m_axis_tuser    // [1:0] status
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_ACT  = 3'b100
    } t_state;

    t_state                      r_state, n_state;
    logic [CNT_W-1:0]            r_held, n_held;
    ismt_pkg::t_action           r_action;
    logic [ismt_pkg::ELEM_W-1:0] r_key;
    logic                        r_out_valid;
    ismt_pkg::t_status           r_status, n_status;
    logic [ismt_pkg::COUNT_W-1:0] r_count;

    logic [ismt_pkg::ELEM_W-1:0] w_data [CAPACITY];
    logic [CAPACITY-1:0]         w_hit;
    logic                        w_found;
    logic [IDX_W-1:0]            w_pos;
    logic                        w_slot_free;
    logic                        w_fire;
    logic                        w_in_accept;
    logic                        w_full;
    ismt_pkg::t_cell_ctl         w_ctl;

    assign w_slot_free   = !r_out_valid || m_axis_tready;
    assign w_fire        = (r_state == S_ACT) && w_slot_free;
    assign s_axis_tready = (r_state == S_IDLE) || w_fire;
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;
    assign w_full        = r_held >= CNT_W'(CAPACITY);
    assign w_found       = |w_hit;

    // at most one cell hits since the stored values are distinct
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_hit[i]) begin
                w_pos = w_pos | IDX_W'(i);
            end
        end
    end

    always_comb begin
        w_ctl.cmp = (r_state == S_CMP);
        w_ctl.ins = w_fire && (r_action == ismt_pkg::ACT_INSERT) && !w_found && !w_full;
        w_ctl.rem = w_fire && (r_action == ismt_pkg::ACT_REMOVE) && w_found;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ismt_pkg::ELEM_W-1:0] w_next;
        if (g == CAPACITY - 1) begin : g_last
            assign w_next = w_data[g];
        end else begin : g_mid
            assign w_next = w_data[g + 1];
        end
        ismt_cell #(
            .INDEX (g),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_key       (r_key),
            .i_held      (r_held),
            .i_pos       (w_pos),
            .i_next_data (w_next),
            .o_data      (w_data[g]),
            .o_hit       (w_hit[g])
        );
    end

    always_comb begin
        n_held   = r_held;
        n_status = ismt_pkg::ST_OK;
        case (r_action)
            ismt_pkg::ACT_INSERT: begin
                if (w_found) begin
                    n_status = ismt_pkg::ST_PRESENT;
                end else if (w_full) begin
                    n_status = ismt_pkg::ST_FULL;
                end else begin
                    n_held = r_held + CNT_W'(1);
                end
            end
            ismt_pkg::ACT_REMOVE: begin
                if (w_found) begin
                    n_held = r_held - CNT_W'(1);
                end else begin
                    n_status = ismt_pkg::ST_ABSENT;
                end
            end
            ismt_pkg::ACT_QUERY: begin
                n_status = w_found ? ismt_pkg::ST_OK : ismt_pkg::ST_ABSENT;
            end
            default: begin
                n_held = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_ACT;
            end
            S_ACT: begin
                if (w_fire) begin
                    n_state = w_in_accept ? S_CMP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_held      <= n_held;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_action <= ismt_pkg::t_action'(s_axis_tuser);
            r_key    <= s_axis_tdata;
        end
        if (w_fire) begin
            r_status <= n_status;
            r_count  <= ismt_pkg::COUNT_W'(n_held);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 8'(r_count);
    assign m_axis_tuser  = r_status;

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_result_from_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid && ($past(r_state) == S_ACT))
        else $error("result not registered after update cycle");

    a_cmp_then_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |=> (r_state == S_ACT))
        else $error("compare cycle not followed by update");

    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.rem |=> (r_held == $past(r_held) - CNT_W'(1)))
        else $error("remove did not drop the count by one");

    a_no_update_outside_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.ins || w_ctl.rem) |-> (r_state == S_ACT) && w_slot_free)
        else $error("table changed outside the update cycle");

endmodule

`default_nettype wire

[dv/integer_set_membership_table_top_tb.sv]
`timescale 1ns / 100ps

module integer_set_membership_table_top_tb;

    localparam int CAPACITY    = ismt_pkg::CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int POOL_SIZE   = 20;
    localparam int CHUNK_ITEMS = 65;
    localparam int NUM_CHUNKS  = 8;

    typedef enum logic [1:0] {
        MODE_FLOW,
        MODE_SEND_SLOW,
        MODE_RECV_SLOW,
        MODE_BOTH_SLOW
    } t_idle_mode;

    typedef struct packed {
        ismt_pkg::t_action  act;
        logic signed [31:0] elem;
    } t_req;

    typedef struct packed {
        ismt_pkg::t_status status;
        logic [4:0]        count;
    } t_result;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // [31:0] element
    logic [1:0]  s_axis_tuser = '0;    // [1:0] action
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire [7:0]   m_axis_tdata;         // [4:0] count, [7:5] zero
    wire [1:0]   m_axis_tuser;         // [1:0] status

    integer_set_membership_table_top #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    t_req        req_q[$];
    t_result     pending_results[$];
    t_idle_mode  idle_mode = MODE_FLOW;
    logic        hold_go = 1'b0;
    logic        hold_on = 1'b0;
    int          hold_cnt = 0;
    int          errors = 0;
    int          n_accepted = 0;
    int          n_results = 0;
    int          cycle_cnt = 0;
    int          status_seen[4] = '{0, 0, 0, 0};
    int          peak_held = 0;
    logic [31:0] value_pool[POOL_SIZE];

    // shadow copy of the table
    logic [31:0] shadow_entries[CAPACITY];
    int          shadow_held = 0;

    function automatic t_result apply_to_shadow(ismt_pkg::t_action act, logic [31:0] v);
        t_result r;
        int pos;
        int i;
        pos = shadow_held;
        for (i = shadow_held - 1; i >= 0; i--) begin
            if (shadow_entries[i] == v) pos = i;
        end
        r.status = ismt_pkg::ST_OK;
        case (act)
            ismt_pkg::ACT_INSERT: begin
                if (pos < shadow_held) begin
                    r.status = ismt_pkg::ST_PRESENT;
                end else if (shadow_held >= CAPACITY) begin
                    r.status = ismt_pkg::ST_FULL;
                end else begin
                    shadow_entries[shadow_held] = v;
                    shadow_held++;
                end
            end
            ismt_pkg::ACT_REMOVE: begin
                if (pos >= shadow_held) begin
                    r.status = ismt_pkg::ST_ABSENT;
                end else begin
                    // close the gap, keeping insertion order
                    for (i = pos; i + 1 < shadow_held; i++)
                        shadow_entries[i] = shadow_entries[i + 1];
                    shadow_held--;
                end
            end
            ismt_pkg::ACT_QUERY: begin
                r.status = (pos < shadow_held) ? ismt_pkg::ST_OK : ismt_pkg::ST_ABSENT;
            end
            default: begin
                shadow_held = 0;
            end
        endcase
        r.count = shadow_held[4:0];
        return r;
    endfunction

    function automatic logic chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic t_req random_req();
        t_req r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)      r.act = ismt_pkg::ACT_INSERT;
        else if (pick < 70) r.act = ismt_pkg::ACT_REMOVE;
        else if (pick < 96) r.act = ismt_pkg::ACT_QUERY;
        else                r.act = ismt_pkg::ACT_CLEAR;
        pick = $urandom_range(0, 99);
        if (pick < 82) begin
            r.elem = value_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (pick < 90) begin
            // one bit away from a pooled value
            r.elem = value_pool[$urandom_range(0, POOL_SIZE - 1)]
                     ^ (32'd1 << $urandom_range(0, 31));
        end else begin
            r.elem = $urandom;
        end
        return r;
    endfunction

    task automatic add_req(ismt_pkg::t_action act, logic [31:0] v);
        t_req r;
        r.act  = act;
        r.elem = v;
        req_q.push_back(r);
    endtask

    task automatic drain();
        while (req_q.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    // request driver
    always @(posedge i_clk) begin : drv
        t_req nxt;
        int   idle_pct;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                pending_results.push_back(
                    apply_to_shadow(ismt_pkg::t_action'(s_axis_tuser), s_axis_tdata));
                n_accepted++;
                if (shadow_held > peak_held) peak_held = shadow_held;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                idle_pct = (idle_mode == MODE_SEND_SLOW) ? 85 :
                           (idle_mode == MODE_BOTH_SLOW) ? 22 : 0;
                if (req_q.size() != 0 && !chance(idle_pct)) begin
                    nxt = req_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.elem;
                    s_axis_tuser  <= nxt.act;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin : holdoff
        if (!i_rst_n) begin
            hold_on  <= 1'b0;
            hold_cnt <= 0;
        end else if (hold_go && hold_cnt < HOLD_CYCLES) begin
            hold_on  <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end else begin
            hold_on <= 1'b0;
        end
    end

    // result monitor
    always @(posedge i_clk) begin : mon
        t_result want;
        int      stall_pct;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                status_seen[m_axis_tuser]++;
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: result with no request waiting: status %0d count %0d",
                             $time, m_axis_tuser, m_axis_tdata[4:0]);
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tuser !== want.status) begin
                        errors++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, m_axis_tuser);
                    end
                    if (m_axis_tdata[4:0] !== want.count) begin
                        errors++;
                        $display("%0t: count mismatch: expected %0d, actual %0d",
                                 $time, want.count, m_axis_tdata[4:0]);
                    end
                    if (m_axis_tdata[7:5] !== 3'd0) begin
                        errors++;
                        $display("%0t: tdata pad mismatch: expected 0, actual %0d",
                                 $time, m_axis_tdata[7:5]);
                    end
                end
            end
            stall_pct = (idle_mode == MODE_RECV_SLOW) ? 85 :
                        (idle_mode == MODE_BOTH_SLOW) ? 22 : 0;
            m_axis_tready <= !hold_on && !chance(stall_pct);
        end
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_cnt, pending_results.size());
        $display("FAILURE");
        $finish;
    end

    initial begin : main
        t_idle_mode plan[NUM_CHUNKS];
        int k;
        int p;
        plan = '{MODE_FLOW, MODE_SEND_SLOW, MODE_RECV_SLOW, MODE_BOTH_SLOW,
                 MODE_FLOW, MODE_BOTH_SLOW, MODE_SEND_SLOW, MODE_RECV_SLOW};
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (k = 4; k < POOL_SIZE; k++) value_pool[k] = $urandom;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, extremes, duplicates, misses, full, clear
        add_req(ismt_pkg::ACT_CLEAR,  32'h0000_0000);
        add_req(ismt_pkg::ACT_QUERY,  32'h0000_0000);
        add_req(ismt_pkg::ACT_REMOVE, 32'hFFFF_FFFF);
        add_req(ismt_pkg::ACT_INSERT, 32'h8000_0000);
        add_req(ismt_pkg::ACT_INSERT, 32'h7FFF_FFFF);
        add_req(ismt_pkg::ACT_INSERT, 32'h0000_0000);
        add_req(ismt_pkg::ACT_INSERT, 32'hFFFF_FFFF);
        add_req(ismt_pkg::ACT_INSERT, 32'h7FFF_FFFF);
        add_req(ismt_pkg::ACT_QUERY,  32'h8000_0000);
        add_req(ismt_pkg::ACT_QUERY,  32'h0000_0001);
        add_req(ismt_pkg::ACT_REMOVE, 32'h0000_0000);
        add_req(ismt_pkg::ACT_REMOVE, 32'h0000_0000);
        for (k = 1; k <= 13; k++) add_req(ismt_pkg::ACT_INSERT, k * 32'h1111_1111);
        add_req(ismt_pkg::ACT_INSERT, 32'h0000_0064);
        add_req(ismt_pkg::ACT_QUERY,  32'h7FFF_FFFF);
        add_req(ismt_pkg::ACT_REMOVE, 32'h8000_0000);
        add_req(ismt_pkg::ACT_REMOVE, 32'hDDDD_DDDD);
        add_req(ismt_pkg::ACT_CLEAR,  32'hFFFF_FFFF);
        drain();

        for (p = 0; p < NUM_CHUNKS; p++) begin
            idle_mode = plan[p];
            // backpressure burst: sink stops while requests keep coming
            if (p == 4) hold_go = 1'b1;
            for (k = 0; k < CHUNK_ITEMS; k++) req_q.push_back(random_req());
            drain();
        end

        repeat (10) @(negedge i_clk);
        $display("ran %0d requests into %0d results over %0d cycles, peak count %0d",
                 n_accepted, n_results, cycle_cnt, peak_held);
        $display("statuses seen: ok %0d, present %0d, absent %0d, full %0d",
                 status_seen[ismt_pkg::ST_OK], status_seen[ismt_pkg::ST_PRESENT],
                 status_seen[ismt_pkg::ST_ABSENT], status_seen[ismt_pkg::ST_FULL]);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[files.f]
src/ismt_pkg.sv
src/ismt_cell.sv
src/integer_set_membership_table_top.sv
dv/integer_set_membership_table_top_tb.sv
